### hw/rtl/dual_graph_shortest_path_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual graph shortest path block
// Each macro checks a property under the block clock; DGSP_ASSERT also uses the reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_GRAPH_SHORTEST_PATH_TOP_DEFINES_SVH
`define DUAL_GRAPH_SHORTEST_PATH_TOP_DEFINES_SVH

`ifndef SYNTH
// Property checked while reset is low.
`define DGSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every edge, reset included.
`define DGSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DGSP_ASSERT(lbl, clk, rst, prop, msg)
`define DGSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hw/rtl/dgsp_pkg.sv
// ----------------------------------------------------------------------------
// Dual graph shortest path package
// Shared constants, codes, state type and controller/datapath interface.
// ----------------------------------------------------------------------------
package dgsp_pkg;

   // Default size of the vertex set.
   localparam int DEF_MAX_VERTICES = 64;

   // Reset values of the source distance registers.
   localparam logic [7:0] LOW_SRC_RESET  = 8'd2;
   localparam logic [7:0] HIGH_SRC_RESET = 8'd1;

   // Operation codes of a request.
   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_EDGE  = 2'd1,
      MODE_RUN   = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_LOW_SRC  = 1'b0,
      CSR_HIGH_SRC = 1'b1
   } csr_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_BOOT_CLEAR,
      ST_IDLE,
      ST_CLEAR,
      ST_EDGE,
      ST_INIT,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_PICK,
      ST_RELAX,
      ST_RELAX_WAIT,
      ST_READ,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic clr_step;
      logic edge_wr;
      logic run_init;
      logic idx_clear;
      logic scan_issue;
      logic settle;
      logic relax_issue;
      logic graph_next;
      logic read_issue;
      logic respond;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_last;
      logic clr_last;
      logic found;
      logic graph;
   } status_type;

endpackage

### hw/rtl/dual_graph_shortest_path_top.sv
// ----------------------------------------------------------------------------
// Dual graph shortest path top level
// Two weighted directed graphs with single-source shortest distances.
//
//   Channel   Handshake             Payload
//   request   start high, busy low  req_mode, req_graph_sel, req_from_vertex,
//                                   req_to_vertex, req_edge_weight,
//                                   req_edge_present
//   response  rsp_valid, one cycle  rsp_low_distance, rsp_low_reached,
//                                   rsp_high_distance, rsp_high_reached,
//                                   rsp_done_res
//   config    csr_we                csr_index, csr_wdata
//
// Edge writes and reads pass ST_EDGE or ST_READ before the response; a clear
// zeroes all adjacency entries (MAX_VERTICES up to a power of two, squared).
// A run handles the low graph, then the high graph; for each settled vertex
// it makes a scan pass and a relax pass over the vertices, over one memory
// port each. After reset a clearing pass over the same entries holds busy high.
// The response strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module dual_graph_shortest_path_top
   import dgsp_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic        req_graph_sel,
   input  logic [5:0]  req_from_vertex,
   input  logic [5:0]  req_to_vertex,
   input  logic [7:0]  req_edge_weight,
   input  logic        req_edge_present,
   output logic        rsp_valid,
   output logic [15:0] rsp_low_distance,
   output logic        rsp_low_reached,
   output logic [15:0] rsp_high_distance,
   output logic        rsp_high_reached,
   output logic        rsp_done_res,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   dgsp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Storage and arithmetic.
   dgsp_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_mode),
      .req_graph_sel     (req_graph_sel),
      .req_from_vertex   (req_from_vertex),
      .req_to_vertex     (req_to_vertex),
      .req_edge_weight   (req_edge_weight),
      .req_edge_present  (req_edge_present),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_low_distance  (rsp_low_distance),
      .rsp_low_reached   (rsp_low_reached),
      .rsp_high_distance (rsp_high_distance),
      .rsp_high_reached  (rsp_high_reached),
      .rsp_done_res      (rsp_done_res)
   );

endmodule

### hw/rtl/dgsp_ctrl.sv
// ----------------------------------------------------------------------------
// Dual graph shortest path controller
// Sequences clearing, edge writes, the two shortest path runs and reads.
// ----------------------------------------------------------------------------
`include "dual_graph_shortest_path_top_defines.svh"

module dgsp_ctrl
   import dgsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_mode,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_BOOT_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (mode_type'(req_mode))
                  MODE_CLEAR: state_in = ST_CLEAR;
                  MODE_EDGE:  state_in = ST_EDGE;
                  MODE_RUN:   state_in = ST_INIT;
                  MODE_READ:  state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_RESP;
         end
         ST_EDGE:      state_in = ST_RESP;
         ST_INIT:      state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.idx_last) state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: state_in = ST_PICK;
         ST_PICK: begin
            if (status.found) state_in = ST_RELAX;
            else if (!status.graph) state_in = ST_INIT;
            else state_in = ST_RESP;
         end
         ST_RELAX: begin
            if (status.idx_last) state_in = ST_RELAX_WAIT;
         end
         ST_RELAX_WAIT: state_in = ST_SCAN;
         ST_READ:       state_in = ST_RESP;
         ST_RESP:       state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE:       cmd.latch = accept;
         ST_BOOT_CLEAR: cmd.clr_step = 1'b1;
         ST_CLEAR:      cmd.clr_step = 1'b1;
         ST_EDGE:       cmd.edge_wr = 1'b1;
         ST_INIT: begin
            cmd.run_init  = 1'b1;
            cmd.idx_clear = 1'b1;
         end
         ST_SCAN:       cmd.scan_issue = 1'b1;
         ST_PICK: begin
            cmd.settle     = status.found;
            cmd.idx_clear  = status.found;
            cmd.graph_next = !status.found && !status.graph;
         end
         ST_RELAX:      cmd.relax_issue = 1'b1;
         ST_RELAX_WAIT: cmd.idx_clear = 1'b1;
         ST_READ:       cmd.read_issue = 1'b1;
         ST_RESP:       cmd.respond = 1'b1;
         default:       cmd = '0;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `DGSP_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted transaction did not raise busy")
   `DGSP_ASSERT(a_resp_idle, clock, reset, cmd.respond |=> (state_ff == ST_IDLE), "response not followed by idle")
   `DGSP_ASSERT(a_scan_drain, clock, reset, (state_ff == ST_SCAN && status.idx_last) |=> (state_ff == ST_SCAN_WAIT), "scan did not drain after last vertex")
   `DGSP_ASSERT(a_settle_found, clock, reset, cmd.settle |-> status.found, "settle without a candidate")

endmodule

### hw/rtl/dgsp_datapath.sv
// ----------------------------------------------------------------------------
// Dual graph shortest path datapath
// Adjacency memories, working distance memories, flags and the relax unit.
// ----------------------------------------------------------------------------
module dgsp_datapath
   import dgsp_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic [1:0]  req_mode,
   input  logic        req_graph_sel,
   input  logic [5:0]  req_from_vertex,
   input  logic [5:0]  req_to_vertex,
   input  logic [7:0]  req_edge_weight,
   input  logic        req_edge_present,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   output logic [15:0] rsp_low_distance,
   output logic        rsp_low_reached,
   output logic [15:0] rsp_high_distance,
   output logic        rsp_high_reached,
   output logic        rsp_done_res
);

   // Working distances hold a full path plus one more edge without wrapping.
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int WW = VW + 9;
   localparam int AW = 2 * VW;

   // Memories.
   logic [8:0]    low_adj_mem  [0:(2**AW)-1];
   logic [8:0]    high_adj_mem [0:(2**AW)-1];
   logic [WW-1:0] low_work_mem  [0:(2**VW)-1];
   logic [WW-1:0] high_work_mem [0:(2**VW)-1];

   // Latched request.
   logic [1:0] mode_ff;
   logic       sel_ff;
   logic [5:0] from_ff;
   logic [5:0] to_ff;
   logic [7:0] wt_ff;
   logic       pres_ff;

   // Control registers.
   logic [7:0]              low_src_ff, low_src_in;
   logic [7:0]              high_src_ff, high_src_in;
   logic                    graph_ff, graph_in;
   logic [VW-1:0]           idx_ff, idx_in;
   logic [VW-1:0]           idx_d_ff;
   logic [AW-1:0]           clr_ff, clr_in;
   logic                    scan_v_ff, relax_v_ff;
   logic                    found_ff, found_in;
   logic [VW-1:0]           best_idx_ff, best_idx_in;
   logic [WW-1:0]           best_dist_ff, best_dist_in;
   logic [MAX_VERTICES-1:0] settled_ff, settled_in;
   logic [MAX_VERTICES-1:0] low_reached_ff, low_reached_in;
   logic [MAX_VERTICES-1:0] high_reached_ff, high_reached_in;

   // Memory read data.
   logic [8:0]    low_adj_rd_ff, high_adj_rd_ff;
   logic [WW-1:0] low_work_rd_ff, high_work_rd_ff;

   // Response registers.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] low_dist_ff, low_dist_in;
   logic        low_reach_ff, low_reach_in;
   logic [15:0] high_dist_ff, high_dist_in;
   logic        high_reach_ff, high_reach_in;

   // Combinational helpers.
   logic                    from_ok, to_ok;
   logic [VW-1:0]           from_v, to_v;
   logic [MAX_VERTICES-1:0] cur_reached;
   logic                    cur_reached_bit;
   logic [WW-1:0]           work_rd;
   logic [8:0]              adj_rd;
   logic [WW-1:0]           nd;
   logic                    relax_upd;
   logic                    work_we;
   logic [VW-1:0]           work_waddr;
   logic [WW-1:0]           work_wdata;
   logic [VW-1:0]           work_raddr;
   logic [AW-1:0]           edge_addr;
   logic [8:0]              edge_data;

   assign from_ok = (32'(from_ff) < 32'(MAX_VERTICES));
   assign to_ok   = (32'(to_ff) < 32'(MAX_VERTICES));
   assign from_v  = VW'(from_ff);
   assign to_v    = VW'(to_ff);

   assign cur_reached     = graph_ff ? high_reached_ff : low_reached_ff;
   assign cur_reached_bit = cur_reached[idx_d_ff];
   assign work_rd         = graph_ff ? high_work_rd_ff : low_work_rd_ff;
   assign adj_rd          = graph_ff ? high_adj_rd_ff : low_adj_rd_ff;

   // Relaxation of one edge out of the settled vertex.
   assign nd        = best_dist_ff + WW'(adj_rd[7:0]);
   assign relax_upd = relax_v_ff && adj_rd[8] && (!cur_reached_bit || (nd < work_rd));

   // Working distance write port: source seed or relaxed distance.
   always_comb begin
      work_we    = 1'b0;
      work_waddr = idx_d_ff;
      work_wdata = nd;
      if (cmd.run_init) begin
         work_we    = from_ok;
         work_waddr = from_v;
         work_wdata = graph_ff ? WW'(high_src_ff) : WW'(low_src_ff);
      end else if (relax_upd) begin
         work_we = 1'b1;
      end
   end

   assign work_raddr = cmd.read_issue ? from_v : idx_ff;
   assign edge_addr  = {from_v, to_v};
   assign edge_data  = pres_ff ? {1'b1, wt_ff} : 9'd0;

   // Next values of the control registers.
   always_comb begin
      low_src_in      = low_src_ff;
      high_src_in     = high_src_ff;
      graph_in        = graph_ff;
      idx_in          = idx_ff;
      clr_in          = clr_ff;
      found_in        = found_ff;
      best_idx_in     = best_idx_ff;
      best_dist_in    = best_dist_ff;
      settled_in      = settled_ff;
      low_reached_in  = low_reached_ff;
      high_reached_in = high_reached_ff;

      // Configuration writes.
      if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_LOW_SRC:  low_src_in = csr_wdata;
            CSR_HIGH_SRC: high_src_in = csr_wdata;
            default:      low_src_in = low_src_ff;
         endcase
      end

      if (cmd.latch) graph_in = 1'b0;
      if (cmd.graph_next) graph_in = 1'b1;

      // Vertex and clearing counters.
      if (cmd.idx_clear) idx_in = '0;
      else if (cmd.scan_issue || cmd.relax_issue) idx_in = idx_ff + 1'b1;
      if (cmd.clr_step) clr_in = clr_ff + 1'b1;

      // Minimum search over unsettled reached vertices.
      if (cmd.idx_clear) begin
         found_in = 1'b0;
      end else if (scan_v_ff && cur_reached_bit && !settled_ff[idx_d_ff] &&
                   (!found_ff || (work_rd < best_dist_ff))) begin
         found_in     = 1'b1;
         best_idx_in  = idx_d_ff;
         best_dist_in = work_rd;
      end

      // Settled and reached flags.
      if (cmd.run_init) begin
         settled_in = '0;
         if (graph_ff) begin
            high_reached_in = '0;
            if (from_ok) high_reached_in[from_v] = 1'b1;
         end else begin
            low_reached_in = '0;
            if (from_ok) low_reached_in[from_v] = 1'b1;
         end
      end
      if (cmd.settle) settled_in[best_idx_ff] = 1'b1;
      if (relax_upd) begin
         if (graph_ff) high_reached_in[idx_d_ff] = 1'b1;
         else low_reached_in[idx_d_ff] = 1'b1;
      end
   end

   // Response fields.
   always_comb begin
      rsp_valid_in  = cmd.respond;
      low_dist_in   = 16'd0;
      low_reach_in  = 1'b0;
      high_dist_in  = 16'd0;
      high_reach_in = 1'b0;
      if (cmd.respond && (mode_type'(mode_ff) == MODE_READ) && from_ok) begin
         low_reach_in  = low_reached_ff[from_v];
         high_reach_in = high_reached_ff[from_v];
         if (low_reached_ff[from_v]) begin
            low_dist_in = (32'(low_work_rd_ff) > 32'(65535)) ? 16'hFFFF
                                                            : 16'(low_work_rd_ff);
         end
         if (high_reached_ff[from_v]) begin
            high_dist_in = (32'(high_work_rd_ff) > 32'(65535)) ? 16'hFFFF
                                                              : 16'(high_work_rd_ff);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_src_ff      <= LOW_SRC_RESET;
         high_src_ff     <= HIGH_SRC_RESET;
         graph_ff        <= 1'b0;
         idx_ff          <= '0;
         clr_ff          <= '0;
         scan_v_ff       <= 1'b0;
         relax_v_ff      <= 1'b0;
         found_ff        <= 1'b0;
         settled_ff      <= '0;
         low_reached_ff  <= '0;
         high_reached_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         low_src_ff      <= low_src_in;
         high_src_ff     <= high_src_in;
         graph_ff        <= graph_in;
         idx_ff          <= idx_in;
         clr_ff          <= clr_in;
         scan_v_ff       <= cmd.scan_issue;
         relax_v_ff      <= cmd.relax_issue;
         found_ff        <= found_in;
         settled_ff      <= settled_in;
         low_reached_ff  <= low_reached_in;
         high_reached_ff <= high_reached_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= req_mode;
         sel_ff  <= req_graph_sel;
         from_ff <= req_from_vertex;
         to_ff   <= req_to_vertex;
         wt_ff   <= req_edge_weight;
         pres_ff <= req_edge_present;
      end
      idx_d_ff      <= idx_ff;
      best_idx_ff   <= best_idx_in;
      best_dist_ff  <= best_dist_in;
      low_dist_ff   <= low_dist_in;
      low_reach_ff  <= low_reach_in;
      high_dist_ff  <= high_dist_in;
      high_reach_ff <= high_reach_in;
   end

   // Low adjacency memory.
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         low_adj_mem[clr_ff] <= 9'd0;
      end else if (cmd.edge_wr && !sel_ff && from_ok && to_ok) begin
         low_adj_mem[edge_addr] <= edge_data;
      end
      low_adj_rd_ff <= low_adj_mem[{best_idx_ff, idx_ff}];
   end

   // High adjacency memory.
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         high_adj_mem[clr_ff] <= 9'd0;
      end else if (cmd.edge_wr && sel_ff && from_ok && to_ok) begin
         high_adj_mem[edge_addr] <= edge_data;
      end
      high_adj_rd_ff <= high_adj_mem[{best_idx_ff, idx_ff}];
   end

   // Low working distance memory.
   always_ff @(posedge clock) begin
      if (work_we && !graph_ff) begin
         low_work_mem[work_waddr] <= work_wdata;
      end
      low_work_rd_ff <= low_work_mem[work_raddr];
   end

   // High working distance memory.
   always_ff @(posedge clock) begin
      if (work_we && graph_ff) begin
         high_work_mem[work_waddr] <= work_wdata;
      end
      high_work_rd_ff <= high_work_mem[work_raddr];
   end

   assign status.idx_last = (idx_ff == VW'(MAX_VERTICES - 1));
   assign status.clr_last = (clr_ff == '1);
   assign status.found    = found_ff;
   assign status.graph    = graph_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_low_distance  = low_dist_ff;
   assign rsp_low_reached   = low_reach_ff;
   assign rsp_high_distance = high_dist_ff;
   assign rsp_high_reached  = high_reach_ff;
   assign rsp_done_res      = rsp_valid_ff;

endmodule
